// ===== rtl/core/bdh_pkg.sv =====
// Shared types and constants for the double-hashed name table.
package bdh_pkg;

  localparam int SLOTS   = 4096;
  localparam int ROWS    = 2048;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int ENTRY_W = ROW_AW + 1;
  localparam int SIZE_W  = 12;
  localparam int PC_W    = 13;
  localparam int KEY_W   = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] name_key;
  } bdh_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ROW_AW-1:0] row_index;
    logic [PC_W-1:0]   probe_count;
  } bdh_out_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] addr;
    logic [ENTRY_W-1:0] wdata;
  } slot_req_t;

  typedef struct packed {
    logic              we;
    logic [ROW_AW-1:0] addr;
    logic [63:0]       wdata;
  } name_req_t;

  typedef struct packed {
    logic              go;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

endpackage

// ===== rtl/core/bdh_ram.sv =====
// Generic single-port RAM with registered read.
module bdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/bdh_mod.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo a 12-bit divisor.
module bdh_mod
  import bdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mod_req_t          req,
  output logic              done,
  output logic [SIZE_W-1:0] rem
);
  logic                     active;
  logic [4:0]               cnt;
  logic [KEY_W-1:0]         dvd;
  logic [SIZE_W-1:0]        dsr;
  logic [SIZE_W:0]          trial;

  assign trial = {rem, dvd[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= !req.go && active && (cnt == 5'd31);
      if (req.go) begin
        dvd    <= req.dividend;
        dsr    <= req.divisor;
        rem    <= '0;
        cnt    <= '0;
        active <= 1'b1;
      end else if (active) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= SIZE_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[SIZE_W-1:0];
        end
        dvd <= dvd << 1;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          active <= 1'b0;
        end
      end
    end
  end
endmodule

// ===== rtl/core/bdh_seq.sv =====
// Sequencer: probe walk, Brent relocation search, commit and clear sweep.
module bdh_seq
  import bdh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bdh_in_t            req,
  input  logic [SIZE_W-1:0]  table_size,
  output logic               busy,
  output logic               rsp_valid,
  output bdh_out_t           rsp,
  output slot_req_t          slot_req,
  input  logic [ENTRY_W-1:0] slot_rd,
  output name_req_t          name_req,
  input  logic [63:0]        name_rd,
  output mod_req_t           mod_req,
  input  logic               mod_done,
  input  logic [SIZE_W-1:0]  mod_rem
);
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_KM1  = 5'd2;
  localparam logic [4:0] S_KM1W = 5'd3;
  localparam logic [4:0] S_KM2  = 5'd4;
  localparam logic [4:0] S_KM2W = 5'd5;
  localparam logic [4:0] S_WRD  = 5'd6;
  localparam logic [4:0] S_WSL  = 5'd7;
  localparam logic [4:0] S_WNM  = 5'd8;
  localparam logic [4:0] S_WEND = 5'd9;
  localparam logic [4:0] S_BCHK = 5'd10;
  localparam logic [4:0] S_BRS  = 5'd11;
  localparam logic [4:0] S_BRN  = 5'd12;
  localparam logic [4:0] S_BDIV = 5'd13;
  localparam logic [4:0] S_BTO  = 5'd14;
  localparam logic [4:0] S_BTS  = 5'd15;
  localparam logic [4:0] S_BEND = 5'd16;
  localparam logic [4:0] S_COM1 = 5'd17;
  localparam logic [4:0] S_COM2 = 5'd18;

  logic [4:0]         state;
  logic [1:0]         cmd;
  logic [63:0]        nm;
  logic [SIZE_W-1:0]  s;
  logic [KEY_W-1:0]   key;
  logic [SLOT_AW-1:0] start_pos, stride, pos, at, to, rstride;
  logic [SLOT_AW-1:0] best_at, best_to, clr_addr;
  logic [PC_W-1:0]    passed, remain, gain, best_gain;
  logic [ENTRY_W-1:0] entry, res, best_res, row_count;
  logic               hit, empty, clr_rsp;
  logic [ENTRY_W-1:0] slot_rd_m1, entry_m1;
  logic [SLOT_AW-1:0] to_step;
  logic [SIZE_W-1:0]  s_in;
  logic               rsp_valid_next;

  // (p + d) mod s with p < s and d < s
  function automatic logic [SLOT_AW-1:0] step_pos(input logic [SLOT_AW-1:0] p,
                                                  input logic [SLOT_AW-1:0] d,
                                                  input logic [SIZE_W-1:0] sz);
    logic [SLOT_AW:0] sum;
    sum = {1'b0, p} + {1'b0, d};
    if (sum >= {1'b0, sz}) begin
      sum = sum - {1'b0, sz};
    end
    return sum[SLOT_AW-1:0];
  endfunction

  assign slot_rd_m1 = slot_rd - ENTRY_W'(1);
  assign entry_m1   = entry - ENTRY_W'(1);
  assign to_step    = step_pos(to, rstride, s);
  // a 12-bit size never exceeds the slot count, so only the low clamp applies
  assign s_in       = (table_size < SIZE_W'(3)) ? SIZE_W'(3) : table_size;
  assign busy       = (state != S_IDLE);

  always_comb begin
    slot_req       = '0;
    name_req       = '0;
    mod_req        = '0;
    rsp_valid_next = 1'b0;
    unique case (state)
      S_IDLE: rsp_valid_next = start && (req.command == CMD_NOP);
      S_CLR: begin
        slot_req.we    = 1'b1;
        slot_req.addr  = clr_addr;
        rsp_valid_next = clr_rsp && (clr_addr == SLOT_AW'(SLOTS - 1));
      end
      S_KM1: begin
        mod_req.go       = 1'b1;
        mod_req.dividend = key;
        mod_req.divisor  = s;
      end
      S_KM2: begin
        mod_req.go       = 1'b1;
        mod_req.dividend = key;
        mod_req.divisor  = s - SIZE_W'(2);
      end
      S_WRD:  slot_req.addr = pos;
      S_WSL:  name_req.addr = slot_rd_m1[ROW_AW-1:0];
      // answer now unless the insert goes on to relocation
      S_WEND: rsp_valid_next = (cmd == CMD_LOOKUP) || hit || !empty ||
                               (row_count >= ENTRY_W'(ROWS));
      S_BCHK: slot_req.addr = at;
      S_BRS:  name_req.addr = slot_rd_m1[ROW_AW-1:0];
      S_BRN: begin
        mod_req.go       = 1'b1;
        mod_req.dividend = name_rd[31:0] + name_rd[63:32];
        mod_req.divisor  = s - SIZE_W'(2);
      end
      S_BTO:  slot_req.addr = to_step;
      S_COM1: begin
        slot_req.we    = (best_gain != '0);
        slot_req.addr  = best_to;
        slot_req.wdata = best_res;
      end
      S_COM2: begin
        slot_req.we    = 1'b1;
        slot_req.addr  = best_at;
        slot_req.wdata = row_count + ENTRY_W'(1);
        name_req.we    = 1'b1;
        name_req.addr  = row_count[ROW_AW-1:0];
        name_req.wdata = nm;
        rsp_valid_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      clr_rsp   <= 1'b0;
      row_count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= req.command;
            nm  <= req.name_key;
            s   <= s_in;
            key <= req.name_key[31:0] + req.name_key[63:32];
            priority case (req.command)
              CMD_CLEAR: begin
                clr_addr <= '0;
                clr_rsp  <= 1'b1;
                state    <= S_CLR;
              end
              CMD_NOP: rsp <= '0;
              default: state <= S_KM1;
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + SLOT_AW'(1);
          if (clr_addr == SLOT_AW'(SLOTS - 1)) begin
            row_count <= '0;
            rsp       <= '0;
            state     <= S_IDLE;
          end
        end
        S_KM1: state <= S_KM1W;
        S_KM1W: begin
          if (mod_done) begin
            start_pos <= mod_rem;
            pos       <= mod_rem;
            state     <= S_KM2;
          end
        end
        S_KM2: state <= S_KM2W;
        S_KM2W: begin
          if (mod_done) begin
            stride <= mod_rem + SLOT_AW'(1);
            passed <= '0;
            hit    <= 1'b0;
            empty  <= 1'b0;
            state  <= S_WRD;
          end
        end
        S_WRD: begin
          state <= (passed == PC_W'(s)) ? S_WEND : S_WSL;
        end
        S_WSL: begin
          entry <= slot_rd;
          if (slot_rd == '0) begin
            empty <= 1'b1;
            state <= S_WEND;
          end else begin
            state <= S_WNM;
          end
        end
        S_WNM: begin
          if (name_rd == nm) begin
            hit   <= 1'b1;
            state <= S_WEND;
          end else begin
            passed <= passed + PC_W'(1);
            pos    <= step_pos(pos, stride, s);
            state  <= S_WRD;
          end
        end
        S_WEND: begin
          rsp.probe_count <= passed;
          if (cmd == CMD_LOOKUP) begin
            rsp.status    <= hit ? ST_OK : ST_NOTFOUND;
            rsp.row_index <= hit ? entry_m1[ROW_AW-1:0] : '0;
            state         <= S_IDLE;
          end else if (hit) begin
            rsp.status    <= ST_DUP;
            rsp.row_index <= entry_m1[ROW_AW-1:0];
            state         <= S_IDLE;
          end else if (!empty || row_count >= ENTRY_W'(ROWS)) begin
            rsp.status    <= ST_FULL;
            rsp.row_index <= '0;
            state         <= S_IDLE;
          end else begin
            best_gain <= '0;
            best_at   <= pos;
            best_to   <= pos;
            at        <= start_pos;
            remain    <= passed;
            state     <= S_BCHK;
          end
        end
        S_BCHK: state <= (remain > PC_W'(1)) ? S_BRS : S_COM1;
        S_BRS: begin
          res   <= slot_rd;
          state <= S_BRN;
        end
        S_BRN: state <= S_BDIV;
        S_BDIV: begin
          if (mod_done) begin
            rstride <= mod_rem + SLOT_AW'(1);
            to      <= at;
            gain    <= remain - PC_W'(1);
            state   <= S_BTO;
          end
        end
        S_BTO: begin
          if (gain != '0) begin
            to    <= to_step;
            state <= S_BTS;
          end else begin
            state <= S_BEND;
          end
        end
        S_BTS: begin
          if (slot_rd == '0) begin
            state <= S_BEND;
          end else begin
            gain  <= gain - PC_W'(1);
            state <= S_BTO;
          end
        end
        S_BEND: begin
          if (gain > best_gain) begin
            best_gain <= gain;
            best_at   <= at;
            best_to   <= to;
            best_res  <= res;
          end
          at     <= step_pos(at, stride, s);
          remain <= remain - PC_W'(1);
          state  <= S_BCHK;
        end
        S_COM1: state <= S_COM2;
        S_COM2: begin
          rsp.status      <= ST_OK;
          rsp.row_index   <= row_count[ROW_AW-1:0];
          rsp.probe_count <= passed;
          row_count       <= row_count + ENTRY_W'(1);
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/brent_double_hash_name_table_top.sv =====
// Name table with double hashing and Brent relocation on insert.
//
// Usage: drive req and pulse start while busy is low; the transaction is
// taken at that edge. Commands: insert, look up, clear, and a no-op.
// Exactly one result per transaction appears on rsp for one cycle with
// rsp_valid high; the receiver cannot hold it off. The next transaction may
// be started in the cycle rsp_valid is high.
// A transaction first forms the start slot and the step with two remainder
// passes, then probes the chain with reads of the slot and name memories,
// then forms the result. An insert with a free slot then runs, for each
// resident on the chain but the last, a slot read, a name read, a remainder
// pass and a compare plus the relocation probes, then finishes the search
// and commits. Clear sweeps all SLOTS (4096) slot memory entries. The no-op
// answers in the cycle after start. Reset starts the same clear sweep with
// busy high and no result. table_size is written through cfg_we/cfg_data;
// the user must write it only while idle; the block does not enforce it.
module brent_double_hash_name_table_top
  import bdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bdh_in_t           req,
  output logic              rsp_valid,
  output bdh_out_t          rsp,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data
);
  logic [SIZE_W-1:0]  table_size;
  slot_req_t          slot_req;
  name_req_t          name_req;
  mod_req_t           mod_req;
  logic [ENTRY_W-1:0] slot_rd;
  logic [63:0]        name_rd;
  logic               mod_done;
  logic [SIZE_W-1:0]  mod_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_W'(11);
    end else if (cfg_we) begin
      table_size <= cfg_data;
    end
  end

  bdh_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_req.we), .addr(slot_req.addr),
    .wdata(slot_req.wdata), .rdata(slot_rd)
  );

  bdh_ram #(.WIDTH(64), .DEPTH(ROWS)) u_name_ram (
    .clk(clk), .we(name_req.we), .addr(name_req.addr),
    .wdata(name_req.wdata), .rdata(name_rd)
  );

  bdh_mod u_mod (
    .clk(clk), .rst(rst), .req(mod_req), .done(mod_done), .rem(mod_rem)
  );

  bdh_seq u_seq (
    .clk(clk), .rst(rst), .start(start), .req(req), .table_size(table_size),
    .busy(busy), .rsp_valid(rsp_valid), .rsp(rsp),
    .slot_req(slot_req), .slot_rd(slot_rd),
    .name_req(name_req), .name_rd(name_rd),
    .mod_req(mod_req), .mod_done(mod_done), .mod_rem(mod_rem)
  );

  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $past(busy) || $past(start))
    else $error("result without a transaction");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.command != CMD_NOP) |=> busy)
    else $error("transaction did not raise busy");

  a_full_row_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_NOTFOUND))
      |-> rsp.row_index == '0)
    else $error("miss result carries a row");
endmodule
